// ----- design/float_mask_bitpack_counter_unit_assert.svh -----
// Assertion macros for the mask bit-pack counter
`ifndef FLOAT_MASK_BITPACK_COUNTER_UNIT_ASSERT_SVH
`define FLOAT_MASK_BITPACK_COUNTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FMBC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FMBC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FMBC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FMBC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- design/fmbc_pkg.sv -----
package fmbc_pkg;
    localparam int unsigned MAX_BYTES_PER_ROW = 4096;
    localparam int unsigned MAX_ROWS = 16384;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned LANES = 8;
    localparam int unsigned BPR_W = 13;
    localparam int unsigned RPC_W = 15;
    localparam int unsigned ROW_CNT_W = 16;
    localparam int unsigned CHUNK_CNT_W = 30;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_CHUNK = 1'd1;
    localparam logic [SAMPLE_W-1:0] POS_INF_BITS = 32'h7F80_0000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_7;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_0;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]             mask_byte;
        logic [ROW_CNT_W-1:0]   row_unmasked;
        logic                   row_end;
        logic [CHUNK_CNT_W-1:0] chunk_unmasked;
        logic                   chunk_end;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_beat_t;
endpackage

// ----- design/fmbc_stream_if.sv -----
interface fmbc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- design/float_mask_bitpack_counter_unit.sv -----
// The result beat is held in an output register. Throughput: one beat of
// eight samples per cycle while the downstream is ready; the output register
// is replaced when the downstream takes it, so stalls cost no bubbles.
// Reset (rst_n low, asynchronous): counters and positions go to zero,
// both limits to one, output empty. No clearing pass.
`include "float_mask_bitpack_counter_unit_assert.svh"
module float_mask_bitpack_counter_unit #(
    parameter int unsigned MAX_BPR = fmbc_pkg::MAX_BYTES_PER_ROW,
    parameter int unsigned MAX_RPC = fmbc_pkg::MAX_ROWS
) (
    input logic clk,
    input logic rst_n,
    fmbc_stream_if.sink   in_ch,
    fmbc_stream_if.source out_ch,
    fmbc_stream_if.sink   cfg
);
    import fmbc_pkg::*;

    localparam int unsigned POS_W = (MAX_BPR > 1) ? $clog2(MAX_BPR) : 1;
    localparam int unsigned IDX_W = (MAX_RPC > 1) ? $clog2(MAX_RPC) : 1;
    localparam int unsigned LIM_W = 17;
    localparam logic [LIM_W-1:0] MAX_BPR_L = LIM_W'(MAX_BPR);
    localparam logic [LIM_W-1:0] MAX_RPC_L = LIM_W'(MAX_RPC);

    logic [BPR_W-1:0] bpr_reg;
    logic [RPC_W-1:0] rpc_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [ROW_CNT_W-1:0] rtot_reg, rtot_next;
    logic [CHUNK_CNT_W-1:0] ctot_reg, ctot_next;
    logic [LIM_W-1:0] bpr_last, rpc_last;
    logic [LIM_W-1:0] bpr_clamp, rpc_clamp;
    logic out_valid_reg;
    out_beat_t out_reg, out_next;
    logic [LANES-1:0] mask;
    logic [3:0] cnt;
    logic [LANES*SAMPLE_W-1:0] samples;
    logic in_fire, row_last, chunk_last;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    // Clamp the limits and form the last positions
    always_comb
    begin
        bpr_clamp = (bpr_reg == '0) ? LIM_W'(1) : LIM_W'(bpr_reg);
        if (bpr_clamp > MAX_BPR_L) bpr_clamp = MAX_BPR_L;
        rpc_clamp = (rpc_reg == '0) ? LIM_W'(1) : LIM_W'(rpc_reg);
        if (rpc_clamp > MAX_RPC_L) rpc_clamp = MAX_RPC_L;
        bpr_last = bpr_clamp - LIM_W'(1);
        rpc_last = rpc_clamp - LIM_W'(1);
    end

    // Accept register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpr_reg <= BPR_W'(1);
            rpc_reg <= RPC_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_BYTES_PER_ROW: bpr_reg <= cfg.payload.data[BPR_W-1:0];
                REG_ROWS_PER_CHUNK: rpc_reg <= cfg.payload.data[RPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Test lanes, count, and advance positions
    always_comb
    begin
        samples = in_ch.payload;
        cnt = '0;
        for (int i = 0; i < LANES; i++)
        begin
            mask[i] = (samples[i*SAMPLE_W +: SAMPLE_W] != '0) &&
                      (samples[i*SAMPLE_W +: SAMPLE_W] <= POS_INF_BITS);
            cnt = cnt + 4'(mask[i]);
        end
        rtot_next = rtot_reg + ROW_CNT_W'(cnt);
        ctot_next = ctot_reg + CHUNK_CNT_W'(cnt);
        row_last = LIM_W'(pos_reg) >= bpr_last;
        chunk_last = row_last && (LIM_W'(row_reg) >= rpc_last);
        out_next.mask_byte = mask;
        out_next.row_unmasked = rtot_next;
        out_next.row_end = row_last;
        out_next.chunk_unmasked = ctot_next;
        out_next.chunk_end = chunk_last;
        pos_next = row_last ? '0 : pos_reg + POS_W'(1);
        row_next = chunk_last ? '0 : (row_last ? row_reg + IDX_W'(1) : row_reg);
        if (row_last) rtot_next = '0;
        if (chunk_last) ctot_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= '0;
            rtot_reg <= '0;
            ctot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pos_reg <= pos_next;
                row_reg <= row_next;
                rtot_reg <= rtot_next;
                ctot_reg <= ctot_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (in_fire) out_reg <= out_next;
    end

    `FMBC_ASSERT_NEXT(a_out_after_in, clk, rst_n, in_fire, out_valid_reg, "no beat after accept")
    `FMBC_ASSERT_IMPL(a_chunk_row, clk, rst_n, (!out_valid_reg || !out_reg.chunk_end || out_reg.row_end), "chunk end without row end")
    `FMBC_ASSERT_NEXT(a_row_clear, clk, rst_n, (in_fire && row_last), (rtot_reg == '0 && pos_reg == '0), "row not cleared")
endmodule
